>>> sv/fws_pkg.sv
package fws_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int NUM_WHEELS = 4;
	localparam int NORM_STEPS = 9;
	localparam int BIG_CYCLES = 48;
	localparam int DIV_STEPS = 34;
	localparam int CNT_W = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] BASE_LEN_RST = 16'd3850;
	localparam logic [15:0] TRACK_LEN_RST = 16'd2662;
	localparam logic [15:0] TIRE_RADIUS_RST = 16'd451;

	// wheel order FL, FR, RL, RR; bit k set where that coordinate is negative
	localparam logic [3:0] WHEEL_X_NEG = 4'b1100;
	localparam logic [3:0] WHEEL_Y_NEG = 4'b0101;

	typedef enum logic [1:0] {
		REG_BASE_LEN    = 2'd0,
		REG_TRACK_LEN   = 2'd1,
		REG_TIRE_RADIUS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0][15:0] speed;
		logic [3:0][15:0] angle;
	} sample_t;

	typedef struct packed {
		logic    avail;
		sample_t smp;
	} fws_q_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_CFIN, ST_ROWMUL, ST_ROWSH,
		ST_NORM, ST_BIG, ST_DIVI, ST_DIV, ST_FIN
	} state_t;

	typedef enum logic [1:0] {COL_COS, COL_SIN, COL_LEV, COL_RHS} col_t;

	typedef enum logic [3:0] {
		NMT_00, NMT_01, NMT_02, NMT_11, NMT_12, NMT_22, NMT_T0, NMT_T1, NMT_T2
	} nmt_sel_t;

	typedef enum logic [3:0] {
		A_NM00, A_NM01, A_NM02, A_NM11, A_NM12, A_NM22,
		A_CF00, A_CF01, A_CF02, A_CF11, A_CF12, A_CF22
	} a_src_t;

	typedef enum logic [3:0] {
		D_CF00, D_CF01, D_CF02, D_CF11, D_CF12, D_CF22, D_DET, D_NUM0, D_NUM1, D_NUM2
	} dst_t;

	typedef struct packed {
		col_t     ci;
		col_t     cj;
		nmt_sel_t dst;
		logic     diag;
	} norm_op_t;

	typedef struct packed {
		a_src_t   a_src;
		nmt_sel_t b_src;
		logic     first;
		logic     neg;
		logic     last;
		dst_t     dst;
	} big_op_t;

	function automatic logic [31:0] atan_lut(logic [3:0] i);
		logic [31:0] v;
		case (i)
			4'd0:  v = 32'h20000000;
			4'd1:  v = 32'h12E4051E;
			4'd2:  v = 32'h09FB385B;
			4'd3:  v = 32'h051111D4;
			4'd4:  v = 32'h028B0D43;
			4'd5:  v = 32'h0145D7E1;
			4'd6:  v = 32'h00A2F61E;
			4'd7:  v = 32'h00517C55;
			4'd8:  v = 32'h0028BE53;
			4'd9:  v = 32'h00145F2F;
			4'd10: v = 32'h000A2F98;
			4'd11: v = 32'h000517CC;
			4'd12: v = 32'h00028BE6;
			4'd13: v = 32'h000145F3;
			4'd14: v = 32'h0000A2FA;
			4'd15: v = 32'h0000517D;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// normal matrix and right-hand sums, one entry per step
	function automatic norm_op_t norm_op(logic [3:0] s);
		norm_op_t o;
		case (s)
			4'd0: o = '{COL_COS, COL_COS, NMT_00, 1'b1};
			4'd1: o = '{COL_COS, COL_SIN, NMT_01, 1'b0};
			4'd2: o = '{COL_COS, COL_LEV, NMT_02, 1'b0};
			4'd3: o = '{COL_SIN, COL_SIN, NMT_11, 1'b1};
			4'd4: o = '{COL_SIN, COL_LEV, NMT_12, 1'b0};
			4'd5: o = '{COL_LEV, COL_LEV, NMT_22, 1'b1};
			4'd6: o = '{COL_COS, COL_RHS, NMT_T0, 1'b0};
			4'd7: o = '{COL_SIN, COL_RHS, NMT_T1, 1'b0};
			4'd8: o = '{COL_LEV, COL_RHS, NMT_T2, 1'b0};
			default: o = '{COL_COS, COL_COS, NMT_00, 1'b0};
		endcase
		return o;
	endfunction

	// cofactors, determinant, adjugate times right-hand side
	function automatic big_op_t big_op(logic [4:0] k);
		big_op_t o;
		case (k)
			5'd0:  o = '{A_NM11, NMT_22, 1'b1, 1'b0, 1'b0, D_CF00};
			5'd1:  o = '{A_NM12, NMT_12, 1'b0, 1'b1, 1'b1, D_CF00};
			5'd2:  o = '{A_NM12, NMT_02, 1'b1, 1'b0, 1'b0, D_CF01};
			5'd3:  o = '{A_NM01, NMT_22, 1'b0, 1'b1, 1'b1, D_CF01};
			5'd4:  o = '{A_NM01, NMT_12, 1'b1, 1'b0, 1'b0, D_CF02};
			5'd5:  o = '{A_NM11, NMT_02, 1'b0, 1'b1, 1'b1, D_CF02};
			5'd6:  o = '{A_NM00, NMT_22, 1'b1, 1'b0, 1'b0, D_CF11};
			5'd7:  o = '{A_NM02, NMT_02, 1'b0, 1'b1, 1'b1, D_CF11};
			5'd8:  o = '{A_NM01, NMT_02, 1'b1, 1'b0, 1'b0, D_CF12};
			5'd9:  o = '{A_NM00, NMT_12, 1'b0, 1'b1, 1'b1, D_CF12};
			5'd10: o = '{A_NM00, NMT_11, 1'b1, 1'b0, 1'b0, D_CF22};
			5'd11: o = '{A_NM01, NMT_01, 1'b0, 1'b1, 1'b1, D_CF22};
			5'd12: o = '{A_CF00, NMT_00, 1'b1, 1'b0, 1'b0, D_DET};
			5'd13: o = '{A_CF01, NMT_01, 1'b0, 1'b0, 1'b0, D_DET};
			5'd14: o = '{A_CF02, NMT_02, 1'b0, 1'b0, 1'b1, D_DET};
			5'd15: o = '{A_CF00, NMT_T0, 1'b1, 1'b0, 1'b0, D_NUM0};
			5'd16: o = '{A_CF01, NMT_T1, 1'b0, 1'b0, 1'b0, D_NUM0};
			5'd17: o = '{A_CF02, NMT_T2, 1'b0, 1'b0, 1'b1, D_NUM0};
			5'd18: o = '{A_CF01, NMT_T0, 1'b1, 1'b0, 1'b0, D_NUM1};
			5'd19: o = '{A_CF11, NMT_T1, 1'b0, 1'b0, 1'b0, D_NUM1};
			5'd20: o = '{A_CF12, NMT_T2, 1'b0, 1'b0, 1'b1, D_NUM1};
			5'd21: o = '{A_CF02, NMT_T0, 1'b1, 1'b0, 1'b0, D_NUM2};
			5'd22: o = '{A_CF12, NMT_T1, 1'b0, 1'b0, 1'b0, D_NUM2};
			5'd23: o = '{A_CF22, NMT_T2, 1'b0, 1'b0, 1'b1, D_NUM2};
			default: o = '{A_NM00, NMT_00, 1'b0, 1'b0, 1'b0, D_CF00};
		endcase
		return o;
	endfunction

endpackage

>>> sv/fws_front.sv
module fws_front import fws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sample_valid,
	input  sample_t     smp_in,
	output logic        busy,
	input  logic        pop,
	output fws_q_t      q_out
);

	sample_t                slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]        count_q;
	logic                   push;

	assign busy  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	// samples marked invalid are taken and dropped here
	assign push  = start & ~busy & sample_valid;
	assign q_out.avail = (count_q != '0);
	assign q_out.smp   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= smp_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/fws_cordic.sv
module fws_cordic import fws_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic               en,
	input  logic               fin,
	input  logic [3:0]         step,
	input  logic [15:0]        angle,
	output logic signed [17:0] cos_v,
	output logic signed [17:0] sin_v
);

	logic signed [16:0] ang, fold;
	logic               flip;
	logic signed [33:0] x_q, y_q, z_q, dx, dy, at, xr, yr;
	logic               flip_q;

	// fold into the right half plane, negate results afterwards
	always_comb begin
		ang  = {angle[15], angle};
		fold = ang;
		flip = 1'b0;
		if (ang > 17'sd16384) begin
			fold = ang - 17'sd32768;
			flip = 1'b1;
		end else if (ang < -17'sd16384) begin
			fold = ang + 17'sd32768;
			flip = 1'b1;
		end
	end

	assign dx = y_q >>> step;
	assign dy = x_q >>> step;
	assign at = $signed({2'b00, atan_lut(step)});
	assign xr = (x_q + 34'sd8192) >>> 14;
	assign yr = (y_q + 34'sd8192) >>> 14;

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {fold[16], fold, 16'b0};
			flip_q <= flip;
		end else if (en) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (fin) begin
			cos_v <= flip_q ? -xr[17:0] : xr[17:0];
			sin_v <= flip_q ? -yr[17:0] : yr[17:0];
		end
	end

endmodule

>>> sv/fws_div.sv
module fws_div import fws_pkg::*; (
	input  logic         clk,
	input  logic         load,
	input  logic         en,
	input  logic [127:0] num,
	input  logic [127:0] den,
	output logic [31:0]  quo
);

	logic [127:0] nabs, rem_q;
	logic [128:0] sh;
	logic [33:0]  low_q, q_q, r;
	logic         neg_q, big_q, zero_q, ge;

	assign nabs = num[127] ? (~num + 128'd1) : num;
	assign sh   = {rem_q, low_q[33]};
	assign ge   = (sh >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q  <= num[127];
			zero_q <= den[127] | (den == '0);
			// quotient at or above 2^34 always saturates
			big_q  <= ({17'b0, nabs[127:17]} >= den);
			rem_q  <= {17'b0, nabs[127:17]};
			low_q  <= {nabs[16:0], 17'b0};
			q_q    <= '0;
		end else if (en) begin
			rem_q <= ge ? sh[127:0] - den : sh[127:0];
			low_q <= {low_q[32:0], 1'b0};
			q_q   <= {q_q[32:0], ge};
		end
	end

	// one extra fraction bit, round half away from zero
	assign r = 34'(({1'b0, q_q} + 35'd1) >> 1);

	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (neg_q) begin
			quo = (big_q || r > 34'h080000000) ? 32'h80000000 : 32'(~r + 34'd1);
		end else begin
			quo = (big_q || r > 34'h07FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
		end
	end

endmodule

>>> sv/fws_back.sv
module fws_back import fws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  fws_q_t             q_in,
	output logic               pop,
	input  logic [15:0]        base_len,
	input  logic [15:0]        track_len,
	input  logic [15:0]        tire_radius,
	output logic               done,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate
);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 cor_load, cor_en, cor_fin, row_mul, row_sh;
	logic                 norm_run, big_run, div_load, div_en, fin;

	logic signed [17:0]   cos_v [NUM_WHEELS];
	logic signed [17:0]   sin_v [NUM_WHEELS];
	logic signed [15:0]   spd_q [NUM_WHEELS];
	logic signed [34:0]   pct_s1 [NUM_WHEELS];
	logic signed [34:0]   pst_s1 [NUM_WHEELS];
	logic signed [32:0]   pb_s1 [NUM_WHEELS];
	logic signed [23:0]   lev_q [NUM_WHEELS];
	logic signed [31:0]   rhs_q [NUM_WHEELS];
	logic signed [36:0]   lev_sum [NUM_WHEELS];
	logic signed [33:0]   rhs_sum [NUM_WHEELS];

	// normal matrix stage
	norm_op_t             nop;
	logic                 nissue;
	logic signed [23:0]   opa [NUM_WHEELS];
	logic signed [31:0]   opb [NUM_WHEELS];
	logic signed [55:0]   nprod_s1 [NUM_WHEELS];
	logic                 nvld_s1, ndiag_s1;
	nmt_sel_t             ndst_s1;
	logic signed [63:0]   nsum;
	logic signed [63:0]   nmt_q [9];

	// wide multiply-accumulate stage
	big_op_t              bop;
	logic                 bissue, bph;
	logic [127:0]         aop;
	logic [63:0]          bopnd;
	logic [31:0]          blimb;
	logic [63:0]          bpp_s1 [4];
	logic                 bvld_s1, bph_s1, bneg_s1;
	big_op_t              bop_s1;
	logic [63:0]          balo_s1;
	logic [127:0]         bsum, bbase, bacc_n, acc_q;
	logic [127:0]         wide_q [10];

	logic [31:0]          quo [3];

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pop      = 1'b0;
		cor_load = 1'b0;
		cor_en   = 1'b0;
		cor_fin  = 1'b0;
		row_mul  = 1'b0;
		row_sh   = 1'b0;
		norm_run = 1'b0;
		big_run  = 1'b0;
		div_load = 1'b0;
		div_en   = 1'b0;
		fin      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_in.avail) begin
					pop      = 1'b1;
					cor_load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				cor_en = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_CFIN;
				end
			end
			ST_CFIN: begin
				cor_fin = 1'b1;
				state_d = ST_ROWMUL;
			end
			ST_ROWMUL: begin
				row_mul = 1'b1;
				state_d = ST_ROWSH;
			end
			ST_ROWSH: begin
				row_sh  = 1'b1;
				cnt_d   = '0;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				norm_run = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NORM_STEPS)) begin
					cnt_d   = '0;
					state_d = ST_BIG;
				end
			end
			ST_BIG: begin
				big_run = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BIG_CYCLES)) begin
					cnt_d   = '0;
					state_d = ST_DIVI;
				end
			end
			ST_DIVI: begin
				div_load = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				div_en = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- sin/cos and rows ----------------
	for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_wheel
		fws_cordic u_cordic (
			.clk   (clk),
			.load  (cor_load),
			.en    (cor_en),
			.fin   (cor_fin),
			.step  (cnt_q[3:0]),
			.angle (q_in.smp.angle[k]),
			.cos_v (cos_v[k]),
			.sin_v (sin_v[k])
		);

		assign lev_sum[k] = (WHEEL_Y_NEG[k] ? 37'(pct_s1[k]) : -37'(pct_s1[k]))
			+ (WHEEL_X_NEG[k] ? -37'(pst_s1[k]) : 37'(pst_s1[k])) + 37'sd4096;
		assign rhs_sum[k] = 34'(pb_s1[k]) + 34'sd8;

		always_ff @(posedge clk) begin
			if (pop) begin
				spd_q[k] <= $signed(q_in.smp.speed[k]);
			end
			if (row_mul) begin
				pct_s1[k] <= cos_v[k] * $signed({1'b0, track_len});
				pst_s1[k] <= sin_v[k] * $signed({1'b0, base_len});
				pb_s1[k]  <= spd_q[k] * $signed({1'b0, tire_radius});
			end
			if (row_sh) begin
				lev_q[k] <= 24'(lev_sum[k] >>> 13);
				rhs_q[k] <= 32'(rhs_sum[k] >>> 4);
			end
		end
	end

	// ---------------- normal equations ----------------
	assign nop    = norm_op(cnt_q[3:0]);
	assign nissue = norm_run && (cnt_q < CNT_W'(NORM_STEPS));

	always_comb begin
		for (int k = 0; k < NUM_WHEELS; k++) begin
			case (nop.ci)
				COL_COS: opa[k] = 24'(cos_v[k]);
				COL_SIN: opa[k] = 24'(sin_v[k]);
				default: opa[k] = lev_q[k];
			endcase
			case (nop.cj)
				COL_COS: opb[k] = 32'(cos_v[k]);
				COL_SIN: opb[k] = 32'(sin_v[k]);
				COL_LEV: opb[k] = 32'(lev_q[k]);
				default: opb[k] = rhs_q[k];
			endcase
		end
	end

	assign nsum = 64'(nprod_s1[0]) + 64'(nprod_s1[1]) + 64'(nprod_s1[2])
		+ 64'(nprod_s1[3]) + {63'b0, ndiag_s1};

	always_ff @(posedge clk) begin
		if (nissue) begin
			for (int k = 0; k < NUM_WHEELS; k++) begin
				nprod_s1[k] <= opa[k] * opb[k];
			end
			ndst_s1  <= nop.dst;
			ndiag_s1 <= nop.diag;
		end
		if (nvld_s1) begin
			nmt_q[ndst_s1] <= nsum;
		end
	end

	// ---------------- adjugate and determinant ----------------
	// each 128x64 product is built in two halves: low then high half of the B operand
	assign bop    = big_op(cnt_q[5:1]);
	assign bph    = cnt_q[0];
	assign bissue = big_run && (cnt_q < CNT_W'(BIG_CYCLES));
	assign bopnd  = nmt_q[bop.b_src];
	assign blimb  = bph ? bopnd[63:32] : bopnd[31:0];

	always_comb begin
		case (bop.a_src)
			A_NM00:  aop = 128'(nmt_q[NMT_00]);
			A_NM01:  aop = 128'(nmt_q[NMT_01]);
			A_NM02:  aop = 128'(nmt_q[NMT_02]);
			A_NM11:  aop = 128'(nmt_q[NMT_11]);
			A_NM12:  aop = 128'(nmt_q[NMT_12]);
			A_NM22:  aop = 128'(nmt_q[NMT_22]);
			A_CF00:  aop = wide_q[D_CF00];
			A_CF01:  aop = wide_q[D_CF01];
			A_CF02:  aop = wide_q[D_CF02];
			A_CF11:  aop = wide_q[D_CF11];
			A_CF12:  aop = wide_q[D_CF12];
			A_CF22:  aop = wide_q[D_CF22];
			default: aop = '0;
		endcase
	end

	// signed high limb of B: subtract A<<64 once
	always_comb begin
		if (!bph_s1) begin
			bsum = {64'b0, bpp_s1[0]} + {32'b0, bpp_s1[1], 32'b0}
				+ {bpp_s1[2], 64'b0} + {bpp_s1[3][31:0], 96'b0};
		end else begin
			bsum = {32'b0, bpp_s1[0], 32'b0} + {bpp_s1[1], 64'b0}
				+ {bpp_s1[2][31:0], 96'b0} - (bneg_s1 ? {balo_s1, 64'b0} : 128'b0);
		end
		bbase  = (bop_s1.first && !bph_s1) ? 128'b0 : acc_q;
		bacc_n = bop_s1.neg ? (bbase - bsum) : (bbase + bsum);
	end

	always_ff @(posedge clk) begin
		if (bissue) begin
			for (int i = 0; i < 4; i++) begin
				bpp_s1[i] <= aop[32*i +: 32] * blimb;
			end
			bop_s1  <= bop;
			bph_s1  <= bph;
			bneg_s1 <= bopnd[63];
			balo_s1 <= aop[63:0];
		end
		if (bvld_s1) begin
			acc_q <= bacc_n;
			if (bop_s1.last && bph_s1) begin
				wide_q[bop_s1.dst] <= bacc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvld_s1 <= 1'b0;
			bvld_s1 <= 1'b0;
			done    <= 1'b0;
		end else begin
			nvld_s1 <= nissue;
			bvld_s1 <= bissue;
			done    <= fin;
		end
	end

	// ---------------- division ----------------
	for (genvar j = 0; j < 3; j++) begin : g_div
		fws_div u_div (
			.clk  (clk),
			.load (div_load),
			.en   (div_en),
			.num  (wide_q[D_NUM0 + j]),
			.den  (wide_q[D_DET]),
			.quo  (quo[j])
		);
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			vel_x    <= quo[0];
			vel_y    <= quo[1];
			yaw_rate <= quo[2];
		end
	end

endmodule

>>> sv/four_wheel_steer_odometry_solver_core.sv
// The solver handles one sample at a time, in this order: 16 CORDIC steps, 32x32 partial
//   products for cofactors/determinant/numerators, then 34 divide steps; it takes the next
//   queued sample only once it has returned to idle.
// A two-deep queue takes up to two more samples while one is solved; busy when it is full.
// Results are a one-cycle done beat; the receiver cannot stall.
// Reset (arst_n low) empties the queue, idles the solver and restores the geometry registers.
module four_wheel_steer_odometry_solver_core import fws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               sample_valid,
	input  logic signed [15:0] speed_front_left,
	input  logic signed [15:0] speed_front_right,
	input  logic signed [15:0] speed_rear_left,
	input  logic signed [15:0] speed_rear_right,
	input  logic signed [15:0] angle_front_left,
	input  logic signed [15:0] angle_front_right,
	input  logic signed [15:0] angle_rear_left,
	input  logic signed [15:0] angle_rear_right,
	output logic               done,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	input  logic               wr_en,
	input  logic [1:0]         wr_idx,
	input  logic [15:0]        wr_data
);

	logic [15:0] base_len_q, track_len_q, tire_radius_q;
	sample_t     smp;
	fws_q_t      q_link;
	logic        pop;

	// geometry registers; index three is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q    <= BASE_LEN_RST;
			track_len_q   <= TRACK_LEN_RST;
			tire_radius_q <= TIRE_RADIUS_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_idx))
				REG_BASE_LEN:    base_len_q    <= wr_data;
				REG_TRACK_LEN:   track_len_q   <= wr_data;
				REG_TIRE_RADIUS: tire_radius_q <= wr_data;
				default: ;
			endcase
		end
	end

	// wheel order FL, FR, RL, RR throughout
	assign smp.speed[0] = speed_front_left;
	assign smp.speed[1] = speed_front_right;
	assign smp.speed[2] = speed_rear_left;
	assign smp.speed[3] = speed_rear_right;
	assign smp.angle[0] = angle_front_left;
	assign smp.angle[1] = angle_front_right;
	assign smp.angle[2] = angle_rear_left;
	assign smp.angle[3] = angle_rear_right;

	// front: accept beat, drop invalid samples, queue the rest
	fws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sample_valid (sample_valid),
		.smp_in       (smp),
		.busy         (busy),
		.pop          (pop),
		.q_out        (q_link)
	);

	// back: sin/cos, rows, normal equations, adjugate solve, rounding divide
	fws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_in        (q_link),
		.pop         (pop),
		.base_len    (base_len_q),
		.track_len   (track_len_q),
		.tire_radius (tire_radius_q),
		.done        (done),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.yaw_rate    (yaw_rate)
	);

endmodule
